/* rtl/core/mfde_pkg.sv */
// Package with shared types and constants of the framebuffer draw engine.
package mfde_pkg;

   typedef enum logic [2:0] {
      KIND_PIXEL = 3'd0,
      KIND_BYTE  = 3'd1,
      KIND_RECT  = 3'd2,
      KIND_LINE  = 3'd3,
      KIND_CLRALL = 3'd4,
      KIND_CLRAREA = 3'd5,
      KIND_READ  = 3'd6,
      KIND_NONE  = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_DIV,
      ST_SPAN,
      ST_RD_WAIT,
      ST_RD_DONE,
      ST_DONE
   } state_type;

   localparam int CSR_WIDTH  = 0;
   localparam int CSR_HEIGHT = 1;
   localparam int QBITS = 16;

endpackage

/* rtl/core/mfde_ram.sv */
// Generic single-port RAM with a registered read.
module mfde_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/mfde_div.sv */
// Restoring divider for the line slope, one quotient bit per cycle.
module mfde_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [27:0] dividend,
   input  logic [11:0] divisor,
   output logic        done,
   output logic [27:0] quotient
);
   logic [27:0] q_ff, q_in;
   logic [12:0] r_ff, r_in;
   logic [4:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [12:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done = 1'b0;
      trial = {r_ff[11:0], q_ff[27]};
      if (go) begin
         q_in = dividend;
         r_in = '0;
         n_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[26:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[26:0], 1'b0};
         end
         n_in = n_ff + 5'd1;
         if (n_ff == 5'd27) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      n_ff <= n_in;
   end

   assign quotient = q_in;
endmodule

/* rtl/core/mono_framebuffer_draw_engine_unit.sv */
// Top level of the monochrome framebuffer draw engine.
// The block keeps a one-bit-per-pixel image of MAX_WIDTH x MAX_HEIGHT pixels
// in a single-port RAM and carries out one drawing command at a time.
// A command beat is taken when start is high and busy is low; the payload is
// the req_ ports. Every command gives exactly one result beat: rsp_valid is
// high for one cycle with rsp_pixel_value, the stored pixel for a read and
// zero for every other command. The receiver cannot stall and need not.
// Commands walk the framebuffer one pixel per cycle through one shared pixel
// stepper and the single RAM port. A pixel writes one point, a read waits for
// the registered RAM read, and an unused kind goes straight to its result beat;
// a byte row walks eight pixels (none when its start point is off the window),
// a rectangle, clear area or vertical line walks its clipped box, a
// non-vertical line runs the slope divider, then walks one pixel per visible
// column, and clear all sweeps the whole RAM. Busy is low for one cycle before
// the next command can be taken, so commands follow each other one at a time.
// After reset the block sweeps the whole RAM to zero, one pixel a cycle,
// while busy stays high; the window registers may be written through the csr_
// port at any time while idle and reset to 128 by 64. Values above the maximum
// act as the maximum.
module mono_framebuffer_draw_engine_unit
   import mfde_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [11:0] req_x_start,
   input  logic signed [11:0] req_y_start,
   input  logic signed [11:0] req_x_end,
   input  logic signed [11:0] req_y_end,
   input  logic [10:0]        req_extent_w,
   input  logic [10:0]        req_extent_h,
   input  logic               req_fill,
   input  logic               req_color,
   input  logic [7:0]         req_pixel_byte,
   output logic               rsp_valid,
   output logic               rsp_pixel_value,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;

   // Configuration registers, clamped on use.
   logic [7:0] width_ff;
   logic [6:0] height_ff;
   logic signed [13:0] win_w, win_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 7'd64;
      end else if (csr_write) begin
         if (csr_index == 1'(CSR_WIDTH)) begin
            width_ff <= csr_data;
         end else begin
            height_ff <= csr_data[6:0];
         end
      end
   end

   always_comb begin
      win_w = (32'(width_ff) > MAX_WIDTH) ? 14'(MAX_WIDTH) : 14'(width_ff);
      win_h = (32'(height_ff) > MAX_HEIGHT) ? 14'(MAX_HEIGHT) : 14'(height_ff);
   end

   // Command registers. Spans run with 14-bit signed coordinates.
   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic signed [13:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic signed [13:0] px_ff, px_in, py_ff, py_in;
   logic signed [13:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic        fill_ff, fill_in, color_ff, color_in;
   logic [7:0]  pb_ff, pb_in;
   logic signed [31:0] s_ff, s_in;
   logic signed [47:0] acc_ff, acc_in;
   logic        res_ff, res_in;
   logic [AW-1:0] wipe_ff, wipe_in;
   logic [11:0] lead_dx;
   logic [39:0] lead_prod;

   // RAM port.
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic          ram_wd, ram_rd;

   mfde_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Slope divider on magnitudes.
   logic        div_go, div_done;
   logic [27:0] div_q;
   logic [11:0] dx_mag;
   logic [11:0] dy_abs;
   logic        dy_neg;
   logic signed [13:0] dy_s;

   assign dy_s   = ye_ff - ys_ff;
   assign dy_neg = dy_s < 0;
   assign dy_abs = dy_neg ? 12'(-dy_s) : 12'(dy_s);
   assign dx_mag = 12'(xe_ff - xs_ff);

   mfde_div u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (div_go),
      .dividend({dy_abs, 16'd0}),
      .divisor (dx_mag),
      .done    (div_done),
      .quotient(div_q)
   );

   // Pixel test for the current walk position.
   logic        in_win, want, span_last_x, span_end;
   logic signed [31:0] line_y;
   logic signed [31:0] cur_y;
   logic [10:0] ext_w_ff, ext_h_ff;
   logic [10:0] ext_w_in, ext_h_in;
   logic signed [13:0] xr_edge, yb_edge;

   // Line y: truncate toward zero. The accumulator is wide enough that a
   // steep line far off the window never wraps back into it.
   logic signed [47:0] acc_adj;
   assign acc_adj = acc_ff + ((acc_ff < 0) ? 48'sd65535 : 48'sd0);
   assign line_y = 32'(acc_adj >>> QBITS);

   assign xr_edge = xs_ff + 14'(ext_w_ff) - 14'sd1;
   assign yb_edge = ys_ff + 14'(ext_h_ff) - 14'sd1;

   always_comb begin
      cur_y = (kind_ff == KIND_LINE && xs_ff != xe_ff) ? line_y : 32'(py_ff);
      in_win = px_ff >= 0 && cur_y >= 0 && px_ff < win_w && cur_y < 32'(win_h);
      unique case (kind_ff)
         KIND_RECT: want = fill_ff || px_ff == xs_ff || py_ff == ys_ff ||
                           px_ff == xr_edge || py_ff == yb_edge;
         KIND_BYTE: want = pb_ff[0];
         default:   want = 1'b1;
      endcase
      span_last_x = px_ff >= x1_ff;
      span_end = span_last_x && (py_ff >= y1_ff);
   end

   assign ram_addr = (state_ff == ST_WIPE) ? wipe_ff :
                     {YW'(cur_y), XW'(px_ff)};

   logic signed [13:0] ax, ay, bx, by, xa_e, ya_e;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      xs_in = xs_ff; ys_in = ys_ff; xe_in = xe_ff; ye_in = ye_ff;
      px_in = px_ff; py_in = py_ff;
      x0_in = x0_ff; x1_in = x1_ff; y1_in = y1_ff;
      fill_in = fill_ff; color_in = color_ff; pb_in = pb_ff;
      s_in = s_ff; acc_in = acc_ff; res_in = res_ff;
      ext_w_in = ext_w_ff; ext_h_in = ext_h_ff;
      wipe_in = wipe_ff;
      lead_dx = '0;
      lead_prod = '0;
      ram_we = 1'b0;
      ram_wd = color_ff;
      div_go = 1'b0;
      rsp_valid = 1'b0;
      ax = 14'(req_x_start); ay = 14'(req_y_start);
      bx = 14'(req_x_end);   by = 14'(req_y_end);
      xa_e = ax + 14'(req_extent_w);
      ya_e = ay + 14'(req_extent_h);
      unique case (state_ff)
         ST_WIPE: begin
            ram_we = 1'b1;
            ram_wd = 1'b0;
            wipe_in = wipe_ff + AW'(1);
            if (&wipe_ff) begin
               state_in = (kind_ff == KIND_CLRALL) ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in = kind_type'(req_kind);
               fill_in = req_fill; color_in = req_color;
               pb_in = req_pixel_byte;
               ext_w_in = req_extent_w; ext_h_in = req_extent_h;
               xs_in = ax; ys_in = ay; xe_in = bx; ye_in = by;
               res_in = 1'b0;
               // Default: empty span.
               px_in = 14'sd1; x1_in = 14'sd0; py_in = 14'sd0; y1_in = 14'sd0;
               x0_in = 14'sd0;
               state_in = ST_SPAN;
               unique case (kind_type'(req_kind))
                  KIND_PIXEL: begin
                     px_in = ax; x0_in = ax; x1_in = ax; py_in = ay; y1_in = ay;
                  end
                  KIND_BYTE: begin
                     if (ax >= 0 && ay >= 0 && ax < win_w && ay < win_h) begin
                        px_in = ax; x0_in = ax; x1_in = ax + 14'sd7;
                        py_in = ay; y1_in = ay;
                     end
                  end
                  KIND_RECT, KIND_CLRAREA: begin
                     if (req_kind == KIND_CLRAREA) color_in = 1'b0;
                     px_in = (ax < 0) ? 14'sd0 : ax;
                     x0_in = (ax < 0) ? 14'sd0 : ax;
                     x1_in = ((xa_e < win_w) ? xa_e : win_w) - 14'sd1;
                     py_in = (ay < 0) ? 14'sd0 : ay;
                     y1_in = ((ya_e < win_h) ? ya_e : win_h) - 14'sd1;
                  end
                  KIND_LINE: begin
                     if (ax == bx) begin
                        px_in = ax; x0_in = ax; x1_in = ax;
                        py_in = (ay < by) ? ay : by;
                        if (py_in < 0) py_in = 14'sd0;
                        y1_in = (ay > by) ? ay : by;
                        if (y1_in > win_h - 14'sd1) y1_in = win_h - 14'sd1;
                     end else begin
                        if (bx < ax) begin
                           xs_in = bx; ys_in = by; xe_in = ax; ye_in = ay;
                        end
                        state_in = ST_DIV;
                        div_go = 1'b0;
                     end
                  end
                  KIND_CLRALL: begin
                     wipe_in = '0;
                     state_in = ST_WIPE;
                  end
                  KIND_READ: begin
                     px_in = ax; py_in = ay;
                     state_in = ST_RD_WAIT;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            // First cycle launches the divider; acc starts at yl, stepped on to x = 0 when xl < 0.
            if (!div_done && s_ff != 32'sd1) begin
               div_go = 1'b1;
               s_in = 32'sd1;
            end else if (div_done) begin
               s_in = dy_neg ? -32'(div_q) : 32'(div_q);
               px_in = (xs_ff < 0) ? 14'sd0 : xs_ff;
               x1_in = (xe_ff < win_w - 14'sd1) ? xe_ff : win_w - 14'sd1;
               y1_in = 14'sd0; py_in = 14'sd0;
               lead_dx = 12'(px_in - xs_ff);
               lead_prod = 40'(lead_dx) * 40'(div_q);
               acc_in = (48'(ys_ff) <<< QBITS) +
                        (dy_neg ? -48'(lead_prod) : 48'(lead_prod));
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (px_ff > x1_ff || py_ff > y1_ff) begin
               state_in = ST_DONE;
            end else begin
               ram_we = in_win && want;
               pb_in = pb_ff >> 1;
               if (span_end) begin
                  state_in = ST_DONE;
               end else if (span_last_x) begin
                  px_in = x0_ff;
                  py_in = py_ff + 14'sd1;
               end else begin
                  px_in = px_ff + 14'sd1;
                  acc_in = acc_ff + s_ff;
               end
            end
         end
         ST_RD_WAIT: state_in = ST_RD_DONE;
         ST_RD_DONE: begin
            res_in = in_win & ram_rd;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            s_in = 32'sd0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         wipe_ff  <= '0;
         kind_ff  <= KIND_NONE;
         s_ff     <= 32'sd0;
      end else begin
         state_ff <= state_in;
         wipe_ff  <= wipe_in;
         kind_ff  <= kind_in;
         s_ff     <= s_in;
      end
      xs_ff <= xs_in; ys_ff <= ys_in; xe_ff <= xe_in; ye_ff <= ye_in;
      px_ff <= px_in; py_ff <= py_in;
      x0_ff <= x0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      fill_ff <= fill_in; color_ff <= color_in; pb_ff <= pb_in;
      acc_ff <= acc_in; res_ff <= res_in;
      ext_w_ff <= ext_w_in; ext_h_ff <= ext_h_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_pixel_value = res_ff;
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the monochrome framebuffer draw engine.
module testbench
   import mfde_pkg::*;
();

   localparam int MAXW = 128;
   localparam int MAXH = 64;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   // The scoreboard keeps its own copy of the image and the window, works out
   // the pixel answer of every accepted command and matches result beats in order.
   class frame_scoreboard;
      bit image[MAXH][MAXW];
      int win_w_reg;
      int win_h_reg;
      bit answers[$];
      int errors;

      function void clear_image();
         foreach (image[y, x]) image[y][x] = 1'b0;
      endfunction

      function void set_window(int idx, int val);
         if (idx == CSR_WIDTH) win_w_reg = val & 8'hFF;
         else win_h_reg = val & 7'h7F;
      endfunction

      function int ww();
         return win_w_reg > MAXW ? MAXW : win_w_reg;
      endfunction

      function int wh();
         return win_h_reg > MAXH ? MAXH : win_h_reg;
      endfunction

      function bit visible(int x, int y);
         return x >= 0 && y >= 0 && x < ww() && y < wh();
      endfunction

      function void plot(int x, int y, bit c);
         if (visible(x, y)) image[y][x] = c;
      endfunction

      // Truncating division toward zero, as the line stepper expects.
      function longint tdiv(longint a, longint b);
         longint q;
         q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
         return ((a < 0) != (b < 0)) ? -q : q;
      endfunction

      function void note_command(kind_type k, int xs, int ys, int xe, int ye,
                                 int w, int h, bit fill, bit c, bit [7:0] pb);
         int x0, x1, y0, y1, xl, yl, xr, yr;
         longint slope;
         bit ans;
         ans = 1'b0;
         case (k)
            KIND_PIXEL: plot(xs, ys, c);
            KIND_BYTE: begin
               if (visible(xs, ys) && pb != 0)
                  for (int i = 0; i < 8 && xs + i < ww(); i++)
                     if (pb[i]) plot(xs + i, ys, c);
            end
            KIND_RECT, KIND_CLRAREA: begin
               x0 = xs > 0 ? xs : 0;
               y0 = ys > 0 ? ys : 0;
               x1 = xs + w < ww() ? xs + w : ww();
               y1 = ys + h < wh() ? ys + h : wh();
               for (int py = y0; py < y1; py++)
                  for (int px = x0; px < x1; px++)
                     if (k == KIND_CLRAREA) plot(px, py, 1'b0);
                     else if (fill || px == xs || py == ys || px == xs + w - 1
                              || py == ys + h - 1)
                        plot(px, py, c);
            end
            KIND_LINE: begin
               if (xs == xe) begin
                  y0 = ys < ye ? ys : ye;
                  y1 = ys < ye ? ye : ys;
                  if (y0 < 0) y0 = 0;
                  if (y1 > wh() - 1) y1 = wh() - 1;
                  for (int py = y0; py <= y1; py++) plot(xs, py, c);
               end else begin
                  if (xs < xe) begin
                     xl = xs; yl = ys; xr = xe; yr = ye;
                  end else begin
                     xl = xe; yl = ye; xr = xs; yr = ys;
                  end
                  slope = tdiv(longint'(yr - yl) * 65536, longint'(xr - xl));
                  x0 = xl > 0 ? xl : 0;
                  x1 = xr < ww() - 1 ? xr : ww() - 1;
                  for (int px = x0; px <= x1; px++)
                     plot(px, int'(tdiv(longint'(yl) * 65536
                                        + longint'(px - xl) * slope, 65536)), c);
               end
            end
            KIND_CLRALL: clear_image();
            KIND_READ: ans = visible(xs, ys) ? image[ys][xs] : 1'b0;
            default: ;
         endcase
         answers = {answers, ans};
      endfunction

      function void check_beat(bit got);
         bit want;
         if (answers.size() == 0) begin
            $error("pixel_value: result beat with nothing expected, actual %0d", got);
            errors++;
            return;
         end
         want = answers.pop_front();
         if (want !== got) begin
            $error("pixel_value: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_kind = '0;
   logic signed [11:0] req_x_start = '0, req_y_start = '0, req_x_end = '0, req_y_end = '0;
   logic [10:0] req_extent_w = '0, req_extent_h = '0;
   logic req_fill = 1'b0, req_color = 1'b0;
   logic [7:0] req_pixel_byte = '0;
   logic rsp_valid, rsp_pixel_value;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   frame_scoreboard board;
   int idle_pct;
   longint cycle_count = 0;

   always #5 clock = ~clock;

   mono_framebuffer_draw_engine_unit u_top (.*);

   // Result beats cannot be held off, so every strobe is checked on the edge
   // that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_beat(rsp_pixel_value);
   end

   // Watchdog: generous against the slowest run, which is dominated by clear
   // all and full-window fills at one pixel per cycle.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sends one command beat. The sender may idle first; start is raised at an
   // edge and the beat goes across on the first edge with busy low. Start is
   // dropped at that edge and the task returns at the next edge, while the block
   // is still busy, so no cycle is lost.
   task automatic send_command(kind_type k, int xs, int ys, int xe, int ye, int w, int h,
                               bit fill, bit c, bit [7:0] pb);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_kind <= k;
      req_x_start <= 12'(xs); req_y_start <= 12'(ys);
      req_x_end <= 12'(xe);   req_y_end <= 12'(ye);
      req_extent_w <= 11'(w); req_extent_h <= 11'(h);
      req_fill <= fill;  req_color <= c;
      req_pixel_byte <= pb;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(k, xs, ys, xe, ye, w, h, fill, c, pb);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every expected beat, then a short settle before a register write.
   task automatic drain();
      while (board.answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_window(int idx, int val);
      csr_write <= 1'b1;
      csr_index <= 1'(idx);
      csr_data <= 8'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_window(idx, val);
      @(posedge clock);
   endtask

   // Coordinates mostly near the window so that drawing lands; the rest span
   // the whole signed range so that every bit toggles.
   function automatic int rand_coord(int span);
      if ($urandom_range(9) < 8) return $urandom_range(span + 8) - 4;
      return $urandom_range(4095) - 2048;
   endfunction

   function automatic int rand_extent();
      int r;
      r = $urandom_range(19);
      if (r < 16) return $urandom_range(24);
      if (r < 19) return $urandom_range(140);
      return $urandom_range(2047);
   endfunction

   task automatic random_command();
      int r;
      kind_type k;
      r = $urandom_range(99);
      if (r < 15) k = KIND_PIXEL;
      else if (r < 30) k = KIND_BYTE;
      else if (r < 45) k = KIND_RECT;
      else if (r < 60) k = KIND_LINE;
      else if (r < 61) k = KIND_CLRALL;
      else if (r < 67) k = KIND_CLRAREA;
      else if (r < 98) k = KIND_READ;
      else k = KIND_NONE;
      send_command(k, rand_coord(MAXW), rand_coord(MAXH), rand_coord(MAXW),
                   rand_coord(MAXH), rand_extent(), rand_extent(),
                   1'($urandom_range(1)), $urandom_range(3) != 0,
                   8'($urandom_range(255)));
   endtask

   initial begin
      board = new();
      board.clear_image();
      board.win_w_reg = 128;
      board.win_h_reg = 64;
      idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: field extremes, every command, clipping at each edge,
      // byte row running off the right edge, vertical and steep lines.
      send_command(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0);
      send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_PIXEL, 127, 63, 0, 0, 0, 0, 0, 1, 0);
      send_command(KIND_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_PIXEL, -2048, 2047, 2047, -2048, 2047, 2047, 1, 1, 8'hFF);
      send_command(KIND_BYTE, 124, 5, 0, 0, 0, 0, 0, 1, 8'hFF);
      send_command(KIND_BYTE, 10, 5, 0, 0, 0, 0, 0, 1, 8'h00);
      send_command(KIND_BYTE, 2, 6, 0, 0, 0, 0, 0, 1, 8'hA5);
      send_command(KIND_READ, 127, 5, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_RECT, -3, -2, 0, 0, 20, 10, 0, 1, 0);
      send_command(KIND_RECT, 100, 50, 0, 0, 40, 30, 1, 1, 0);
      send_command(KIND_RECT, 5, 5, 0, 0, 0, 7, 1, 1, 0);
      send_command(KIND_LINE, 30, -10, 30, 80, 0, 0, 0, 1, 0);
      send_command(KIND_LINE, 120, 60, -5, 2, 0, 0, 0, 1, 0);
      send_command(KIND_LINE, 0, 0, 3, 63, 0, 0, 0, 1, 0);
      send_command(KIND_LINE, 2047, -2048, -2048, 2047, 0, 0, 0, 1, 0);
      send_command(KIND_READ, 30, 20, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_CLRAREA, 100, 40, 0, 0, 2047, 2047, 0, 0, 0);
      send_command(KIND_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_NONE, 1, 1, 0, 0, 0, 0, 0, 1, 0);
      send_command(KIND_CLRALL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      // Random phases with several windows, extremes and oversized values
      // among them; pixels outside a shrunken window must keep their values.
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: begin write_window(CSR_WIDTH, 128); write_window(CSR_HEIGHT, 64); end
            1: begin write_window(CSR_WIDTH, 255); write_window(CSR_HEIGHT, 127); end
            2: begin write_window(CSR_WIDTH, 1);   write_window(CSR_HEIGHT, 1); end
            3: begin write_window(CSR_WIDTH, 0);   write_window(CSR_HEIGHT, 0); end
            4: begin
               write_window(CSR_WIDTH, $urandom_range(1, 128));
               write_window(CSR_HEIGHT, $urandom_range(1, 64));
            end
            5: begin write_window(CSR_WIDTH, 37);  write_window(CSR_HEIGHT, 64); end
            6: begin write_window(CSR_WIDTH, 128); write_window(CSR_HEIGHT, 9); end
            default: begin write_window(CSR_WIDTH, 128); write_window(CSR_HEIGHT, 64); end
         endcase
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 24;
            default: idle_pct = 75;
         endcase
         for (int n = 0; n < 116; n++) random_command();
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (board.answers.size() != 0)
            $error("pixel_value: %0d expected beats never arrived", board.answers.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/mfde_pkg.sv
rtl/core/mfde_ram.sv
rtl/core/mfde_div.sv
rtl/core/mono_framebuffer_draw_engine_unit.sv
sim/testbench.sv
